[rtl/core/ll1_table_parser_defines.svh]
// Assertion macros used by the parser checker.
`ifndef LL1_TABLE_PARSER_DEFINES_SVH
`define LL1_TABLE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet while in reset
`define LL1_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ll1 assertion failed");

// Next-cycle implication, sampled on clk, quiet while in reset
`define LL1_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ll1 assertion failed");

`endif

[rtl/core/ll1_pkg.sv]
// Shared constants, codes and types of the LL(1) table parser.
package ll1_pkg;

  localparam int STACK_DEPTH  = 64;
  localparam int NONTERMINALS = 8;
  localparam int PROD_LEN     = 4;
  localparam int STEP_LIMIT   = 256;

  localparam int SYM_W    = 8;
  localparam int PROD_SLOTS = 4;
  localparam int PROD_CAP = (PROD_LEN < PROD_SLOTS) ? PROD_LEN : PROD_SLOTS;
  localparam int SLOT_W   = (NONTERMINALS > 1) ? $clog2(NONTERMINALS) : 1;
  localparam int TBL_DEPTH = NONTERMINALS * 256;
  localparam int TBL_AW   = $clog2(TBL_DEPTH);
  localparam int STK_AW   = $clog2(STACK_DEPTH);
  localparam int TOP_W    = $clog2(STACK_DEPTH + 1);
  localparam int STEP_W   = $clog2(STEP_LIMIT + 1);

  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  // Commands carried in tuser
  localparam logic [2:0] CMD_LOAD_KEY   = 3'd0;
  localparam logic [2:0] CMD_LOAD_ENTRY = 3'd1;
  localparam logic [2:0] CMD_START      = 3'd2;
  localparam logic [2:0] CMD_FEED       = 3'd3;
  localparam logic [2:0] CMD_END        = 3'd4;

  // Parse status codes
  localparam logic [2:0] ST_RUNNING  = 3'd0;
  localparam logic [2:0] ST_ACCEPTED = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_NO_ENTRY = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_EXTRA    = 3'd5;
  localparam logic [2:0] ST_STEPS    = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_SYM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON   = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_POP,
    S_TOP,
    S_TBL,
    S_PUSH,
    S_DONE
  } state_t;

  // Key lookup answer
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } key_hit_t;

  // Production table entry
  typedef struct packed {
    logic                             valid;
    logic [2:0]                       len;
    logic [PROD_SLOTS-1:0][SYM_W-1:0] sym;
  } prod_t;

  localparam int PROD_W = $bits(prod_t);

endpackage

[rtl/core/ll1_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
module ll1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/ll1_keys.sv]
// Nonterminal key store with priority match on the highest slot.
module ll1_keys (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             we,
  input  logic [ll1_pkg::SLOT_W-1:0]       wslot,
  input  logic [ll1_pkg::SYM_W-1:0]        wcode,
  input  logic [ll1_pkg::SYM_W-1:0]        code,
  output ll1_pkg::key_hit_t                hit
);

  logic [ll1_pkg::NONTERMINALS-1:0] valid_r;
  logic [ll1_pkg::SYM_W-1:0]        key_r [ll1_pkg::NONTERMINALS];

  // Clear valid bits on reset, set on load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[wslot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_r[wslot] <= wcode;
    end
  end

  // Match all slots; the highest matching slot wins
  always_comb begin
    hit = '0;
    for (int k = 0; k < ll1_pkg::NONTERMINALS; k++) begin
      if (valid_r[k] && key_r[k] == code) begin
        hit.hit  = 1'b1;
        hit.slot = ll1_pkg::SLOT_W'(k);
      end
    end
  end

endmodule

[rtl/core/ll1_table_parser.sv]
// Top level: LL(1) predictive parser sequencer around stack and table RAMs.
// After reset a clearing pass writes all 2048 table entries; no input is taken meanwhile.
// Loads, start and ignored items each pass through the done state, which issues a result.
// Feed/end items pop, look up and push symbols until a check ends the item; the next item
// is taken only after its result is issued, and a held result stalls the parser.
// Reset (rst_n, synchronous): empty stack, status running, keys invalid, registers to defaults.
module ll1_table_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: slot[2:0], symbol_code[10:3], entry_valid[11], prod_len[14:12],
  //        prod_sym0[22:15], prod_sym1[30:23], prod_sym2[38:31], prod_sym3[46:39], pad
  input  logic [ll1_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: command[2:0]
  input  logic [ll1_pkg::IN_USER_W-1:0]      in_tuser,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // tdata: status[2:0], finished[3], stack_depth[10:4], pad
  output logic [ll1_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ll1_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ll1_pkg::SYM_W-1:0]          cfg_data
);

  ll1_pkg::state_t state_r, state_nxt;

  logic [ll1_pkg::TOP_W-1:0]  top_r, top_nxt;
  logic [2:0]                 status_r, status_nxt;
  logic [ll1_pkg::STEP_W-1:0] steps_r, steps_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic [ll1_pkg::TBL_AW-1:0] clr_r, clr_nxt;
  logic [ll1_pkg::SYM_W-1:0]  chr_r, chr_nxt;
  logic                       at_end_r, at_end_nxt;
  logic [ll1_pkg::SYM_W-1:0]  bottom_r, bottom_nxt;
  logic [ll1_pkg::SYM_W-1:0]  start_sym_r, end_mark_r, eps_r;
  logic                       out_valid_r, out_valid_nxt;
  logic [ll1_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Input fields
  logic [2:0]                       in_cmd;
  logic [ll1_pkg::SLOT_W-1:0]       in_slot;
  logic [ll1_pkg::SYM_W-1:0]        in_code;
  logic [2:0]                       in_len;
  logic                             in_fire;
  logic                             slot_ok;

  // Stack RAM port
  logic                             stk_we, stk_re;
  logic [ll1_pkg::STK_AW-1:0]       stk_waddr, stk_raddr;
  logic [ll1_pkg::SYM_W-1:0]        stk_wdata, stk_rdata;

  // Table RAM port
  logic                             tbl_we, tbl_re;
  logic [ll1_pkg::TBL_AW-1:0]       tbl_waddr, tbl_raddr;
  ll1_pkg::prod_t                   tbl_wdata, tbl_rdata;

  // Key store
  logic                             key_we;
  ll1_pkg::key_hit_t                key_hit;

  logic [ll1_pkg::TOP_W:0]          push_end;
  logic                             run_ok;

  assign in_cmd   = in_tuser[2:0];
  assign in_slot  = ll1_pkg::SLOT_W'(in_tdata[2:0]);
  assign in_code  = in_tdata[10:3];
  assign in_len   = (in_tdata[14:12] > 3'(ll1_pkg::PROD_CAP)) ?
                    3'(ll1_pkg::PROD_CAP) : in_tdata[14:12];
  assign slot_ok  = ({1'b0, in_tdata[2:0]} < 4'(ll1_pkg::NONTERMINALS));
  assign in_tready = (state_r == ll1_pkg::S_IDLE);
  assign in_fire  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign run_ok   = (status_r == ll1_pkg::ST_RUNNING) && (top_r != '0);
  assign push_end = {1'b0, top_r} + (ll1_pkg::TOP_W + 1)'(tbl_rdata.len);

  ll1_ram #(.WIDTH(ll1_pkg::SYM_W), .DEPTH(ll1_pkg::STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  ll1_ram #(.WIDTH(ll1_pkg::PROD_W), .DEPTH(ll1_pkg::TBL_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  ll1_keys u_keys (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (key_we),
    .wslot (in_slot),
    .wcode (in_code),
    .code  (stk_rdata),
    .hit   (key_hit)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ll1_pkg::S_CLEAR: begin
        if (clr_r == ll1_pkg::TBL_AW'(ll1_pkg::TBL_DEPTH - 1)) state_nxt = ll1_pkg::S_IDLE;
      end
      ll1_pkg::S_IDLE: begin
        if (in_fire) begin
          if ((in_cmd == ll1_pkg::CMD_FEED || in_cmd == ll1_pkg::CMD_END) && run_ok) begin
            state_nxt = ll1_pkg::S_POP;
          end else begin
            state_nxt = ll1_pkg::S_DONE;
          end
        end
      end
      ll1_pkg::S_POP: begin
        if (top_r <= ll1_pkg::TOP_W'(1) ||
            steps_r >= ll1_pkg::STEP_W'(ll1_pkg::STEP_LIMIT)) begin
          state_nxt = ll1_pkg::S_DONE;
        end else begin
          state_nxt = ll1_pkg::S_TOP;
        end
      end
      ll1_pkg::S_TOP: begin
        if (key_hit.hit) begin
          state_nxt = ll1_pkg::S_TBL;
        end else if (stk_rdata == eps_r) begin
          state_nxt = ll1_pkg::S_POP;
        end else if (stk_rdata == chr_r && at_end_r) begin
          state_nxt = ll1_pkg::S_POP;
        end else begin
          state_nxt = ll1_pkg::S_DONE;
        end
      end
      ll1_pkg::S_TBL: begin
        if (!tbl_rdata.valid || push_end > (ll1_pkg::TOP_W + 1)'(ll1_pkg::STACK_DEPTH)) begin
          state_nxt = ll1_pkg::S_DONE;
        end else if (tbl_rdata.len == 3'd0) begin
          state_nxt = ll1_pkg::S_POP;
        end else begin
          state_nxt = ll1_pkg::S_PUSH;
        end
      end
      ll1_pkg::S_PUSH: begin
        if (cnt_r == 3'd1) state_nxt = ll1_pkg::S_POP;
      end
      ll1_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ll1_pkg::S_IDLE;
      end
      default: state_nxt = ll1_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    top_nxt      = top_r;
    status_nxt   = status_r;
    steps_nxt    = steps_r;
    cnt_nxt      = cnt_r;
    clr_nxt      = clr_r;
    chr_nxt      = chr_r;
    at_end_nxt   = at_end_r;
    bottom_nxt   = bottom_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt = out_data_r;
    stk_we    = 1'b0;
    stk_waddr = top_r[ll1_pkg::STK_AW-1:0];
    stk_wdata = tbl_rdata.sym[2'(cnt_r - 3'd1)];
    stk_re    = 1'b0;
    stk_raddr = ll1_pkg::STK_AW'(top_r - ll1_pkg::TOP_W'(1));
    tbl_we    = 1'b0;
    tbl_waddr = {in_slot, in_code};
    tbl_wdata = '0;
    tbl_re    = 1'b0;
    tbl_raddr = {key_hit.slot, chr_r};
    key_we    = 1'b0;
    case (state_r)
      ll1_pkg::S_CLEAR: begin
        // Sweep the table to invalid entries
        tbl_we    = 1'b1;
        tbl_waddr = clr_r;
        clr_nxt   = clr_r + ll1_pkg::TBL_AW'(1);
      end
      ll1_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            ll1_pkg::CMD_LOAD_KEY: key_we = slot_ok;
            ll1_pkg::CMD_LOAD_ENTRY: begin
              tbl_we = slot_ok;
              tbl_wdata.valid = in_tdata[11];
              tbl_wdata.len   = in_len;
              tbl_wdata.sym   = in_tdata[46:15];
            end
            ll1_pkg::CMD_START: begin
              // Sentinel held in a register, start symbol at entry one
              bottom_nxt = end_mark_r;
              stk_we     = 1'b1;
              stk_waddr  = ll1_pkg::STK_AW'(1);
              stk_wdata  = start_sym_r;
              top_nxt    = ll1_pkg::TOP_W'(2);
              status_nxt = ll1_pkg::ST_RUNNING;
            end
            ll1_pkg::CMD_FEED, ll1_pkg::CMD_END: begin
              chr_nxt    = (in_cmd == ll1_pkg::CMD_END) ? end_mark_r : in_code;
              at_end_nxt = (in_cmd == ll1_pkg::CMD_END);
              steps_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      ll1_pkg::S_POP: begin
        if (top_r <= ll1_pkg::TOP_W'(1)) begin
          if (!at_end_r) begin
            status_nxt = ll1_pkg::ST_EXTRA;
          end else if (top_r == ll1_pkg::TOP_W'(1) && bottom_r == end_mark_r) begin
            status_nxt = ll1_pkg::ST_ACCEPTED;
          end else begin
            status_nxt = ll1_pkg::ST_MISMATCH;
          end
        end else if (steps_r >= ll1_pkg::STEP_W'(ll1_pkg::STEP_LIMIT)) begin
          status_nxt = ll1_pkg::ST_STEPS;
        end else begin
          // Pop and read the old top
          steps_nxt = steps_r + ll1_pkg::STEP_W'(1);
          top_nxt   = top_r - ll1_pkg::TOP_W'(1);
          stk_re    = 1'b1;
        end
      end
      ll1_pkg::S_TOP: begin
        if (key_hit.hit) begin
          tbl_re = 1'b1;
        end else if (stk_rdata != eps_r && stk_rdata != chr_r) begin
          status_nxt = ll1_pkg::ST_MISMATCH;
        end
      end
      ll1_pkg::S_TBL: begin
        if (!tbl_rdata.valid) begin
          status_nxt = ll1_pkg::ST_NO_ENTRY;
        end else if (push_end > (ll1_pkg::TOP_W + 1)'(ll1_pkg::STACK_DEPTH)) begin
          status_nxt = ll1_pkg::ST_OVERFLOW;
        end else begin
          cnt_nxt = tbl_rdata.len;
        end
      end
      ll1_pkg::S_PUSH: begin
        // Push rightmost symbol first
        stk_we  = 1'b1;
        top_nxt = top_r + ll1_pkg::TOP_W'(1);
        cnt_nxt = cnt_r - 3'd1;
      end
      ll1_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = ll1_pkg::OUT_DATA_W'({top_r,
                                                status_r != ll1_pkg::ST_RUNNING,
                                                status_r});
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ll1_pkg::S_CLEAR;
      top_r       <= '0;
      status_r    <= ll1_pkg::ST_RUNNING;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      start_sym_r <= 8'd83;
      end_mark_r  <= 8'd36;
      eps_r       <= 8'd35;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      status_r    <= status_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ll1_pkg::CFG_START_SYM: start_sym_r <= cfg_data;
          ll1_pkg::CFG_END_MARK:  end_mark_r  <= cfg_data;
          ll1_pkg::CFG_EPSILON:   eps_r       <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    steps_r    <= steps_nxt;
    cnt_r      <= cnt_nxt;
    chr_r      <= chr_nxt;
    at_end_r   <= at_end_nxt;
    bottom_r   <= bottom_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/core/ll1_table_parser_chk.sv]
// Port-level checker for the parser, bound to the top level.
`include "ll1_table_parser_defines.svh"

module ll1_table_parser_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ll1_pkg::OUT_DATA_W-1:0] out_tdata
);

  // Hold a stalled result
  `LL1_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // Finished flag follows status
  `LL1_ASSERT_IMP(a_fin_flag, out_tvalid, out_tdata[3] == (out_tdata[2:0] != 3'd0))
  // Acceptance leaves only the sentinel
  `LL1_ASSERT_IMP(a_acc_depth, out_tvalid && out_tdata[2:0] == 3'd1, out_tdata[10:4] == 7'd1)
  // Depth stays within the stack
  `LL1_ASSERT_IMP(a_depth_max, out_tvalid, out_tdata[10:4] <= 7'(ll1_pkg::STACK_DEPTH))

endmodule

bind ll1_table_parser ll1_table_parser_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
